[sv/csks_pkg.sv]
// ---------------------------------------------------------------------------
// Cosine top-k search: shared types and constants
// Item formats, the kept-entry record, state codes and the control word of
// the square-root and divide unit.
// ---------------------------------------------------------------------------
package csks_pkg;

   localparam int TOP_COUNT  = 30;
   localparam int MAX_DIM    = 1024;
   localparam int ELEM_W     = 16;
   localparam int ADDR_W     = $clog2(MAX_DIM);
   localparam int POS_W      = ADDR_W + 1;
   localparam int CNT_W      = $clog2(TOP_COUNT + 1);
   localparam int SUM_W      = 48;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int LEN_W      = 20;
   localparam int IDX_W      = 16;
   localparam int SCORE_W    = 16;
   localparam int NUM_W      = 64;
   localparam int DEN_W      = 2 * ROOT_W + 1;
   localparam int QUOT_W     = 18;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int STEP_W     = 5;
   localparam int SCORE_ONE  = 16384;

   localparam logic [1:0] KIND_QUERY = 2'd0;
   localparam logic [1:0] KIND_CAND  = 2'd1;
   localparam logic [1:0] KIND_EMIT  = 2'd2;

   typedef struct packed {
      logic [1:0]               kind;
      logic [IDX_W-1:0]         candidate_index;
      logic signed [ELEM_W-1:0] element_value;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]          result_index;
      logic signed [SCORE_W-1:0] score;
      logic [LEN_W-1:0]          candidate_length;
      logic [LEN_W-1:0]          query_length;
      logic                      entry_valid;
      logic                      last_result;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]          index;
      logic signed [SCORE_W-1:0] score;
      logic [LEN_W-1:0]          clen;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ELEM,
      ST_QROOT,
      ST_CROOT,
      ST_SCALE,
      ST_DIV,
      ST_PLACE,
      ST_EROOT,
      ST_EMIT
   } state_type;

   typedef enum logic {
      ARITH_ROOT,
      ARITH_DIV
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_req_type;

endpackage

[sv/cosine_top_k_search.sv]
// ---------------------------------------------------------------------------
// Cosine top-k search
// Streams a query and candidate vectors, keeps the best-scoring candidates.
// ---------------------------------------------------------------------------
// Input items (req_*): kind 0 loads one query element, kind 1 one candidate
// element, kind 2 emits the kept entries and clears them; kind 3 is dropped.
// req_stall is high while an item is in work. An element item is accepted
// and reads the query memory, then forms its products in ST_ELEM.
// The last element of a candidate then runs two 24-step square roots, one
// multiply, an 18-step division in the shared arithmetic unit (skipped if a
// length is zero), and the placement of the entry in the sorted keep list.
// An emit first takes the query length root, then gives one result item
// per cycle in ascending score order while rsp_stall is low; an empty store
// gives one item with entry_valid low. A stalled result holds in the output
// register while the block already takes the next input item.
// csr_write_data sets the query index (candidates with it are skipped).
// Reset clears all counters, sums and the query index, and empties the keep
// list by clearing its count; the query memory needs no clearing pass.
// ---------------------------------------------------------------------------
module cosine_top_k_search
   import csks_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   state_type state_ff, state_in;

   logic [POS_W-1:0]    fill_ff, fill_in, pos_ff, pos_in;
   logic                closed_ff, closed_in;
   logic [SUM_W-1:0]    qsum_ff, qsum_in, csum_ff, csum_in, dot_ff, dot_in;
   logic signed [ELEM_W-1:0] v_ff;
   logic                use_dot_ff, use_sq_ff, to_query_ff, fin_ff;
   logic                pend_dot_ff, pend_q_ff, pend_c_ff;
   logic signed [31:0]  pdot_ff;
   logic [31:0]         psq_ff;
   logic [IDX_W-1:0]    cidx_ff, qidx_ff;
   logic [ROOT_W-1:0]   ql_ff, cl_ff;
   logic [SUM_W-1:0]    den_ff, mag_ff;
   logic                neg_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic [LEN_W-1:0]    qlen_ff;
   entry_type           keep_ff [TOP_COUNT];
   entry_type           keep_in [TOP_COUNT];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                busy_ff, busy_in;

   logic                accept, acc_query, acc_cand, store_q;
   logic                out_free, load, skip, ins, evict, clear_sums;
   logic                computing, arith_done, arith_ovf;
   arith_req_type       arith_req;
   logic [ROOT_W-1:0]   arith_root;
   logic [QUOT_W-1:0]   arith_quot;
   logic [SUM_W-1:0]    radicand;
   logic [NUM_W-1:0]    numer;
   logic [DEN_W-1:0]    divisor;
   logic [ELEM_W-1:0]   ram_rdata;
   logic [ADDR_W-1:0]   ram_waddr;
   logic                le [TOP_COUNT];
   logic                g  [TOP_COUNT];
   entry_type           new_entry;
   logic [LEN_W-1:0]    clen_sat, root_sat;
   logic [QUOT_W-1:0]   qmag;
   logic signed [SCORE_W-1:0] div_score;

   // ---------------- control ----------------
   assign accept    = req_valid && state_ff == ST_IDLE;
   assign req_stall = state_ff != ST_IDLE;
   assign acc_query = accept && req_data.kind == KIND_QUERY;
   assign acc_cand  = accept && req_data.kind == KIND_CAND;
   assign store_q   = closed_ff || fill_ff < POS_W'(MAX_DIM);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign skip      = cidx_ff == qidx_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_QUERY, KIND_CAND: state_in = ST_ELEM;
                  KIND_EMIT:             state_in = ST_EROOT;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_ELEM:  state_in = fin_ff ? ST_QROOT : ST_IDLE;
         ST_QROOT: if (arith_done) state_in = ST_CROOT;
         ST_CROOT: if (arith_done) state_in = ST_SCALE;
         ST_SCALE: state_in = (ql_ff == '0 || cl_ff == '0) ? ST_PLACE : ST_DIV;
         ST_DIV:   if (arith_done) state_in = ST_PLACE;
         ST_PLACE: if (!evict) state_in = ST_IDLE;
         ST_EROOT: if (arith_done) state_in = ST_EMIT;
         ST_EMIT:  if (out_free && count_ff <= CNT_W'(1)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      computing = state_ff inside {ST_QROOT, ST_CROOT, ST_DIV, ST_EROOT};
      arith_req.start = computing && !busy_ff;
      arith_req.op    = (state_ff == ST_DIV) ? ARITH_DIV : ARITH_ROOT;
      busy_in    = computing && !arith_done;
      load       = state_ff == ST_EMIT && out_free;
      ins        = state_ff == ST_PLACE && !skip && count_ff < CNT_W'(TOP_COUNT);
      evict      = state_ff == ST_PLACE && !skip && count_ff == CNT_W'(TOP_COUNT)
                   && score_ff > keep_ff[0].score;
      clear_sums = state_ff == ST_PLACE && !evict;
   end

   // ---------------- query memory ----------------
   assign ram_waddr = closed_ff ? '0 : fill_ff[ADDR_W-1:0];

   csks_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM)) u_query_ram (
      .clock   (clock),
      .wr_en   (acc_query && store_q),
      .wr_addr (ram_waddr),
      .wr_data (req_data.element_value),
      .rd_addr (pos_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // ---------------- arithmetic ----------------
   assign radicand = (state_ff == ST_CROOT) ? csum_ff : qsum_ff;
   assign numer    = {1'b0, mag_ff, 15'b0} + {{(NUM_W-SUM_W){1'b0}}, den_ff};
   assign divisor  = {den_ff, 1'b0};

   csks_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .radicand  (radicand),
      .numer     (numer),
      .divisor   (divisor),
      .done      (arith_done),
      .root      (arith_root),
      .quot      (arith_quot),
      .ovf       (arith_ovf)
   );

   assign root_sat = (|arith_root[ROOT_W-1:LEN_W]) ? '1 : arith_root[LEN_W-1:0];
   assign clen_sat = (|cl_ff[ROOT_W-1:LEN_W]) ? '1 : cl_ff[LEN_W-1:0];
   assign qmag     = (arith_ovf || arith_quot > QUOT_W'(SCORE_ONE))
                     ? QUOT_W'(SCORE_ONE) : arith_quot;
   assign div_score = neg_ff ? -$signed(qmag[SCORE_W-1:0]) : $signed(qmag[SCORE_W-1:0]);

   // ---------------- datapath next values ----------------
   always_comb begin
      fill_in   = fill_ff;
      closed_in = closed_ff;
      pos_in    = pos_ff;
      if (acc_query) begin
         if (store_q) begin
            fill_in = (closed_ff ? '0 : fill_ff) + 1'b1;
         end
         closed_in = req_data.last_element;
      end
      if (acc_cand) begin
         if (pos_ff < POS_W'(MAX_DIM)) begin
            pos_in = pos_ff + 1'b1;
         end
         if (req_data.last_element) begin
            pos_in = '0;
         end
      end

      qsum_in = qsum_ff;
      if (acc_query && closed_ff) begin
         qsum_in = '0;
      end else if (pend_q_ff) begin
         qsum_in = qsum_ff + {16'b0, psq_ff};
      end
      csum_in = csum_ff;
      dot_in  = dot_ff;
      if (clear_sums) begin
         csum_in = '0;
         dot_in  = '0;
      end else begin
         if (pend_c_ff) csum_in = csum_ff + {16'b0, psq_ff};
         if (pend_dot_ff) dot_in = dot_ff + {{16{pdot_ff[31]}}, pdot_ff};
      end

      count_in = count_ff;
      if (ins) count_in = count_ff + 1'b1;
      else if (evict) count_in = count_ff - 1'b1;
      else if (load && count_ff != '0) count_in = count_ff - 1'b1;
   end

   // sorted keep list: le marks entries that stay ahead of the new one
   assign new_entry = '{index: cidx_ff, score: score_ff, clen: clen_sat};

   always_comb begin
      for (int i = 0; i < TOP_COUNT; i++) begin
         le[i] = keep_ff[i].score <= score_ff;
         g[i]  = (CNT_W'(i) >= count_ff) || !le[i];
      end
      for (int i = 0; i < TOP_COUNT; i++) begin
         keep_in[i] = keep_ff[i];
      end
      if (evict || (load && count_ff != '0)) begin
         for (int i = 0; i < TOP_COUNT - 1; i++) begin
            keep_in[i] = keep_ff[i+1];
         end
      end else if (ins) begin
         if (g[0]) keep_in[0] = new_entry;
         for (int i = 1; i < TOP_COUNT; i++) begin
            if (g[i]) keep_in[i] = g[i-1] ? keep_ff[i-1] : new_entry;
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (count_ff == '0) begin
            rsp_in = '{result_index: '0, score: '0, candidate_length: '0,
                       query_length: qlen_ff, entry_valid: 1'b0, last_result: 1'b1};
         end else begin
            rsp_in = '{result_index: keep_ff[0].index, score: keep_ff[0].score,
                       candidate_length: keep_ff[0].clen, query_length: qlen_ff,
                       entry_valid: 1'b1, last_result: count_ff == CNT_W'(1)};
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         closed_ff    <= 1'b0;
         pos_ff       <= '0;
         qsum_ff      <= '0;
         csum_ff      <= '0;
         dot_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         pend_dot_ff  <= 1'b0;
         pend_q_ff    <= 1'b0;
         pend_c_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         qidx_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         closed_ff    <= closed_in;
         pos_ff       <= pos_in;
         qsum_ff      <= qsum_in;
         csum_ff      <= csum_in;
         dot_ff       <= dot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         pend_dot_ff  <= state_ff == ST_ELEM && use_dot_ff;
         pend_q_ff    <= state_ff == ST_ELEM && use_sq_ff && to_query_ff;
         pend_c_ff    <= state_ff == ST_ELEM && use_sq_ff && !to_query_ff;
         if (accept) fin_ff <= acc_cand && req_data.last_element;
         if (csr_write_enable) qidx_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         v_ff        <= req_data.element_value;
         to_query_ff <= req_data.kind == KIND_QUERY;
         use_sq_ff   <= acc_query ? store_q : pos_ff < POS_W'(MAX_DIM);
         use_dot_ff  <= acc_cand && pos_ff < POS_W'(MAX_DIM) && pos_ff < fill_ff;
         if (acc_cand && req_data.last_element) cidx_ff <= req_data.candidate_index;
      end
      if (state_ff == ST_ELEM) begin
         pdot_ff <= v_ff * $signed(ram_rdata);
         psq_ff  <= 32'(v_ff * v_ff);
      end
      if (state_ff == ST_QROOT && arith_done) ql_ff <= arith_root;
      if (state_ff == ST_CROOT && arith_done) cl_ff <= arith_root;
      if (state_ff == ST_EROOT && arith_done) qlen_ff <= root_sat;
      if (state_ff == ST_SCALE) begin
         den_ff   <= ql_ff * cl_ff;
         neg_ff   <= dot_ff[SUM_W-1];
         mag_ff   <= dot_ff[SUM_W-1] ? -dot_ff : dot_ff;
         score_ff <= '0;
      end
      if (state_ff == ST_DIV && arith_done) score_ff <= div_score;
      for (int i = 0; i < TOP_COUNT; i++) begin
         keep_ff[i] <= keep_in[i];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TOP_COUNT))
      else $error("keep count above capacity");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |-> rsp_data.last_result)
      else $error("empty emit result not marked last");

   a_pend_after_elem: assert property (@(posedge clock) disable iff (reset)
      (pend_dot_ff || pend_c_ff || pend_q_ff) |-> $past(state_ff == ST_ELEM))
      else $error("accumulate without a product stage");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> busy_ff)
      else $error("arithmetic done without a request");

endmodule

[sv/csks_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module csks_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/csks_arith.sv]
// ---------------------------------------------------------------------------
// Cosine top-k search: iterative arithmetic unit
// Integer square root (two bits per step) and restoring division (one
// quotient bit per step), sharing one step counter.
// ---------------------------------------------------------------------------
module csks_arith
   import csks_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  arith_req_type     arith_req,
   input  logic [SUM_W-1:0]  radicand,
   input  logic [NUM_W-1:0]  numer,
   input  logic [DEN_W-1:0]  divisor,
   output logic              done,
   output logic [ROOT_W-1:0] root,
   output logic [QUOT_W-1:0] quot,
   output logic              ovf
);

   localparam int DSH_W = DEN_W + QUOT_W - 1;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   arith_op_type      op_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [SUM_W-1:0]  x_ff, res_ff, bit_ff;
   logic [NUM_W-1:0]  rem_ff;
   logic [DSH_W-1:0]  dsh_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic              ovf_ff;
   logic [SUM_W:0]    trial;
   logic              root_ge, div_ge;

   assign trial   = {1'b0, res_ff} + {1'b0, bit_ff};
   assign root_ge = {1'b0, x_ff} >= trial;
   assign div_ge  = {{(DSH_W-NUM_W){1'b0}}, rem_ff} >= dsh_ff;

   assign run_in  = arith_req.start ? 1'b1 : (run_ff && cnt_ff != '0);
   assign done_in = run_ff && cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (arith_req.start) begin
         op_ff   <= arith_req.op;
         x_ff    <= radicand;
         res_ff  <= '0;
         bit_ff  <= SUM_W'(1) << (SUM_W - 2);
         rem_ff  <= numer;
         dsh_ff  <= {divisor, {(QUOT_W-1){1'b0}}};
         quot_ff <= '0;
         ovf_ff  <= {3'b0, numer} >= {divisor, {QUOT_W{1'b0}}};
         cnt_ff  <= (arith_req.op == ARITH_ROOT) ? STEP_W'(ROOT_STEPS - 1)
                                                 : STEP_W'(DIV_STEPS - 1);
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (op_ff == ARITH_ROOT) begin
            if (root_ge) begin
               x_ff   <= x_ff - trial[SUM_W-1:0];
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end else begin
            if (div_ge) begin
               rem_ff <= rem_ff - dsh_ff[NUM_W-1:0];
            end
            quot_ff <= {quot_ff[QUOT_W-2:0], div_ge};
            dsh_ff  <= dsh_ff >> 1;
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];
   assign quot = quot_ff;
   assign ovf  = ovf_ff;

endmodule

[sim/cosine_top_k_search_tb.sv]
// ---------------------------------------------------------------------------
// Cosine top-k search testbench
// Streams query and candidate vectors under random burst and stall patterns,
// predicts every emitted result in the testbench and checks each field in
// order. Directed cases come first, then random vectors and emits.
// ---------------------------------------------------------------------------
module cosine_top_k_search_tb;
   import csks_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   req_type pending_items[$];
   rsp_type expected_results[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      long_hold_request = 1'b0;
   bit      long_hold_done = 1'b0;

   // predictor state
   logic signed [ELEM_W-1:0] query_mem[MAX_DIM];
   int unsigned              query_fill;
   logic [47:0]              query_sq;
   bit                       query_done;
   int unsigned              cand_pos;
   logic [47:0]              cand_dot;
   logic [47:0]              cand_sq;
   entry_type                keep_list[TOP_COUNT];
   int                       keep_count;
   logic [15:0]              skip_index;

   always #10 clock = ~clock;

   cosine_top_k_search DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= root + probe) begin
            x    = x - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic logic [LEN_W-1:0] clip_length(logic [63:0] len);
      return (len > 64'hFFFFF) ? 20'hFFFFF : len[LEN_W-1:0];
   endfunction

   function automatic logic signed [SCORE_W-1:0] cosine_of_candidate();
      logic [63:0] qlen;
      logic [63:0] clen;
      logic [63:0] denom;
      logic [63:0] quot;
      logic [47:0] magnitude;
      bit          negative;
      qlen = int_sqrt({16'b0, query_sq});
      clen = int_sqrt({16'b0, cand_sq});
      if (qlen == 0 || clen == 0) return '0;
      negative  = cand_dot[47];
      magnitude = negative ? -cand_dot : cand_dot;
      denom     = qlen * clen;
      quot      = (({16'b0, magnitude} << 15) + denom) / (denom << 1);
      if (quot > SCORE_ONE) quot = SCORE_ONE;
      return negative ? -quot[SCORE_W-1:0] : quot[SCORE_W-1:0];
   endfunction

   function automatic void keep_candidate(entry_type e);
      int low;
      if (keep_count < TOP_COUNT) begin
         keep_list[keep_count] = e;
         keep_count++;
         return;
      end
      low = 0;
      for (int i = 1; i < keep_count; i++)
         if (keep_list[i].score < keep_list[low].score) low = i;
      if (!(e.score > keep_list[low].score)) return;
      // evict the earliest minimum, keep insertion order for the rest
      for (int i = low; i + 1 < keep_count; i++) keep_list[i] = keep_list[i+1];
      keep_list[keep_count-1] = e;
   endfunction

   function automatic void predict_item(req_type r);
      longint    value;
      longint    product;
      entry_type e;
      entry_type hold;
      rsp_type   out;
      int        j;
      logic [LEN_W-1:0] qlen;
      value = longint'(r.element_value);
      if (r.kind == KIND_QUERY) begin
         if (query_done) begin
            query_fill = 0;
            query_sq   = '0;
            query_done = 1'b0;
         end
         if (query_fill < MAX_DIM) begin
            query_mem[query_fill] = r.element_value;
            product  = value * value;
            query_sq = query_sq + product[47:0];
            query_fill++;
         end
         if (r.last_element) query_done = 1'b1;
      end else if (r.kind == KIND_CAND) begin
         if (cand_pos < MAX_DIM) begin
            if (cand_pos < query_fill) begin
               product  = value * longint'(query_mem[cand_pos]);
               cand_dot = cand_dot + product[47:0];
            end
            product = value * value;
            cand_sq = cand_sq + product[47:0];
            cand_pos++;
         end
         if (r.last_element) begin
            if (r.candidate_index != skip_index) begin
               e.index = r.candidate_index;
               e.score = cosine_of_candidate();
               e.clen  = clip_length(int_sqrt({16'b0, cand_sq}));
               keep_candidate(e);
            end
            cand_pos = 0;
            cand_dot = '0;
            cand_sq  = '0;
         end
      end else if (r.kind == KIND_EMIT) begin
         qlen = clip_length(int_sqrt({16'b0, query_sq}));
         if (keep_count == 0) begin
            out = '0;
            out.query_length = qlen;
            out.last_result  = 1'b1;
            expected_results.push_back(out);
            return;
         end
         for (int i = 1; i < keep_count; i++) begin
            hold = keep_list[i];
            j = i;
            while (j > 0 && keep_list[j-1].score > hold.score) begin
               keep_list[j] = keep_list[j-1];
               j--;
            end
            keep_list[j] = hold;
         end
         for (int i = 0; i < keep_count; i++) begin
            out.result_index     = keep_list[i].index;
            out.score            = keep_list[i].score;
            out.candidate_length = keep_list[i].clen;
            out.query_length     = qlen;
            out.entry_valid      = 1'b1;
            out.last_result      = (i + 1 == keep_count);
            expected_results.push_back(out);
         end
         keep_count = 0;
      end
   endfunction

   // driver: bursts of items with random gaps
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_item(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall pattern
   int hold_left = 0;
   always @(posedge clock) begin
      rsp_type want;
      int      mode;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[cosine_top_k_search] ERROR");
         $finish;
      end else begin
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result: actual %p", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.result_index !== want.result_index)
                  $display("%0t result_index: expected %0d actual %0d", $time,
                           want.result_index, rsp_data.result_index);
               if (rsp_data.score !== want.score)
                  $display("%0t score: expected %0d actual %0d", $time,
                           want.score, rsp_data.score);
               if (rsp_data.candidate_length !== want.candidate_length)
                  $display("%0t candidate_length: expected %0d actual %0d", $time,
                           want.candidate_length, rsp_data.candidate_length);
               if (rsp_data.query_length !== want.query_length)
                  $display("%0t query_length: expected %0d actual %0d", $time,
                           want.query_length, rsp_data.query_length);
               if (rsp_data.entry_valid !== want.entry_valid)
                  $display("%0t entry_valid: expected %0d actual %0d", $time,
                           want.entry_valid, rsp_data.entry_valid);
               if (rsp_data.last_result !== want.last_result)
                  $display("%0t last_result: expected %0d actual %0d", $time,
                           want.last_result, rsp_data.last_result);
               if (rsp_data !== want) error_count++;
            end
         end
         mode = (cycle_count / 400) % 3;
         // start the long hold once a result is waiting
         if (long_hold_request && !long_hold_done && hold_left == 0 && rsp_valid) begin
            hold_left <= 600;
            long_hold_done <= 1'b1;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else if (mode == 0) begin
            rsp_stall <= 1'b0;
         end else if (mode == 1) begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic add_item(logic [1:0] kind, logic [15:0] idx, logic [15:0] val, bit last);
      req_type r;
      r.kind            = kind;
      r.candidate_index = idx;
      r.element_value   = val;
      r.last_element    = last;
      pending_items.push_back(r);
   endtask

   task automatic add_random_vector(logic [1:0] kind, logic [15:0] idx, int len, bit narrow);
      logic [15:0] val;
      for (int i = 0; i < len; i++) begin
         if (narrow) begin
            case ($urandom_range(0, 3))
               0: val = 16'h1000;
               1: val = 16'hF000;
               2: val = 16'h0800;
               default: val = 16'h0000;
            endcase
         end else begin
            val = 16'($urandom);
         end
         add_item(kind, idx, val, i == len - 1);
      end
   endtask

   task automatic wait_until_idle();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      // the last candidate can still be in work with no result due
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_skip_index(logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      skip_index = value;
   endtask

   initial begin
      int len;
      int pick;
      query_fill = 0;
      query_sq   = '0;
      query_done = 1'b0;
      cand_pos   = 0;
      cand_dot   = '0;
      cand_sq    = '0;
      keep_count = 0;
      skip_index = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_skip_index(16'hFFFF);

      // directed: empty emit, candidate with no query, ignored kind
      add_item(KIND_EMIT, 0, 0, 0);
      add_item(KIND_CAND, 16'd5, 16'h1000, 1);
      add_item(2'd3, 16'hFFFF, 16'hFFFF, 1);
      add_item(KIND_QUERY, 0, 16'h7FFF, 0);
      add_item(KIND_QUERY, 0, 16'h8000, 0);
      add_item(KIND_QUERY, 0, 16'h1000, 1);
      add_item(KIND_CAND, 16'hFFFF, 16'h1000, 0);   // skipped index
      add_item(KIND_CAND, 16'hFFFF, 16'h2000, 1);
      add_item(KIND_CAND, 16'd7, 16'h0000, 1);      // zero length
      add_item(KIND_CAND, 16'h8000, 16'h8000, 0);   // longer than query
      add_item(KIND_CAND, 16'h8000, 16'h7FFF, 0);
      add_item(KIND_CAND, 16'h8000, 16'h0064, 0);
      add_item(KIND_CAND, 16'h8000, 16'h0005, 1);
      add_item(KIND_CAND, 16'd1, 16'h7FFF, 0);      // same as query
      add_item(KIND_CAND, 16'd1, 16'h8000, 0);
      add_item(KIND_CAND, 16'd1, 16'h1000, 1);
      add_item(KIND_CAND, 16'd2, 16'h8001, 0);      // opposite of query
      add_item(KIND_CAND, 16'd2, 16'h7FFF, 0);
      add_item(KIND_CAND, 16'd2, 16'hF000, 1);
      add_item(KIND_EMIT, 0, 0, 0);
      add_item(KIND_QUERY, 0, 16'hF000, 1);         // new query
      add_item(KIND_CAND, 16'd9, 16'h3000, 0);
      add_item(KIND_EMIT, 0, 0, 0);                 // emit mid-candidate
      add_item(KIND_CAND, 16'd9, 16'h0400, 1);
      add_item(KIND_EMIT, 0, 0, 1);
      wait_until_idle();
      write_skip_index(16'd4);

      // fill past the keep limit with many tied scores, under a long hold
      add_random_vector(KIND_QUERY, 0, 2, 1);
      for (int i = 0; i < 10; i++) add_random_vector(KIND_CAND, 16'(i), 2, 1);
      add_item(KIND_EMIT, 0, 0, 0);
      for (int i = 0; i < 40; i++)
         add_random_vector(KIND_CAND, 16'($urandom_range(0, 40)), 1, 1);
      add_item(KIND_EMIT, 0, 0, 0);
      long_hold_request = 1'b1;
      wait_until_idle();

      // random phases
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) write_skip_index(16'hFFFF);
         else write_skip_index(16'($urandom));
         for (int n = 0; n < 7; n++) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 6);
            if (pick < 10) begin
               add_random_vector(KIND_QUERY, 0, len, phase[0]);
            end else if (pick < 20) begin
               add_item(KIND_EMIT, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            end else if (pick < 24) begin
               add_item(2'd3, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            end else if (pick < 30) begin
               add_item(KIND_CAND, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            end else if (pick < 36) begin
               add_random_vector(KIND_CAND, skip_index, len, phase[0]);
            end else begin
               add_random_vector(KIND_CAND, 16'($urandom), len, phase[0]);
            end
         end
         add_item(KIND_EMIT, 0, 0, 0);
         wait_until_idle();
      end

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[cosine_top_k_search] OK");
      end else begin
         $display("[cosine_top_k_search] ERROR");
      end
      $finish;
   end

endmodule
